// ===== hw/rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache_core; no dependencies.
package lkvc_pkg;

   // Store geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W   = IDX_W;
   localparam int COUNT_W = $clog2(ENTRIES + 1);

   // Field widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Request codes
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   typedef logic [AGE_W-1:0] age_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic match;
      logic update;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } status_type;

endpackage

// ===== hw/rtl/lkvc_ctrl.sv =====
// Sequencing state machine of the LRU key-value cache.
// Depends on lkvc_pkg; drives the command word to lkvc_datapath.
module lkvc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                rsp_stall,
   input  lkvc_pkg::status_type status,
   output lkvc_pkg::cmd_type   cmd
);

   lkvc_pkg::state_type state_ff;
   lkvc_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lkvc_pkg::ST_MATCH;
            end
         end
         lkvc_pkg::ST_MATCH: begin
            cmd.match = 1'b1;
            // advance only once the output register will be free
            if (!status.rsp_busy || !rsp_stall) begin
               state_in = lkvc_pkg::ST_UPDATE;
            end
         end
         lkvc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lkvc_datapath.sv =====
// Entry store, parallel key match, recency ranks and output register of the cache.
// Depends on lkvc_pkg; steered by the command word from lkvc_ctrl.
module lkvc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lkvc_pkg::cmd_type                  cmd,
   output lkvc_pkg::status_type               status,
   input  logic                               req_action,
   input  logic signed [lkvc_pkg::KEY_W-1:0]   req_lookup_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0] req_write_value,
   input  logic                               csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]          csr_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic signed [lkvc_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                               rsp_evicted
);

   localparam int N = lkvc_pkg::ENTRIES;

   // Captured request word
   logic                          req_put_ff;
   logic [lkvc_pkg::KEY_W-1:0]    req_key_ff;
   logic [lkvc_pkg::VALUE_W-1:0]  req_value_ff;

   // Entry store
   logic [lkvc_pkg::KEY_W-1:0]    keys_ff   [N];
   logic [lkvc_pkg::VALUE_W-1:0]  values_ff [N];
   logic [N-1:0]                  valid_ff;
   logic [N-1:0]                  valid_in;
   lkvc_pkg::age_type             age_ff [N];
   lkvc_pkg::age_type             age_in [N];
   logic [lkvc_pkg::COUNT_W-1:0]  live_count_ff;
   logic [lkvc_pkg::COUNT_W-1:0]  live_count_in;
   logic [lkvc_pkg::CAP_W-1:0]    capacity_ff;

   // Match stage registers
   logic                          hit_ff;
   logic [N-1:0]                  found_mask_ff;
   lkvc_pkg::age_type             found_age_ff;
   logic [lkvc_pkg::VALUE_W-1:0]  found_value_ff;
   logic                          evict_ff;
   logic [N-1:0]                  victim_mask_ff;

   // Output register
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic [lkvc_pkg::VALUE_W-1:0]  rsp_read_value_ff;
   logic                          rsp_evicted_ff;

   // Match stage logic
   logic [N-1:0]                  match_vec;
   logic [N-1:0]                  victim_vec;
   lkvc_pkg::age_type             match_age;
   logic [lkvc_pkg::VALUE_W-1:0]  match_value;
   lkvc_pkg::age_type             last_rank;
   logic [lkvc_pkg::CMP_W-1:0]    cap_ext;
   logic [lkvc_pkg::CMP_W-1:0]    eff_cap;
   logic                          need_evict;

   // Update stage logic
   logic [N-1:0]                  kept_vec;
   logic [N-1:0]                  free_vec;
   logic [N-1:0]                  slot_vec;
   logic                          slot_found;
   logic                          insert;
   logic                          rsp_take;

   // Capture request and configuration
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_put_ff   <= req_action;
         req_key_ff   <= req_lookup_key;
         req_value_ff <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // Compare the key against every live entry; find the oldest by its rank
   always_comb begin
      match_age   = '0;
      match_value = '0;
      last_rank   = lkvc_pkg::AGE_W'(live_count_ff - lkvc_pkg::COUNT_W'(1));
      for (int i = 0; i < N; i++) begin
         match_vec[i]  = valid_ff[i] && (keys_ff[i] == req_key_ff);
         victim_vec[i] = valid_ff[i] && (age_ff[i] == last_rank);
         if (match_vec[i]) begin
            match_age   = match_age | age_ff[i];
            match_value = match_value | values_ff[i];
         end
      end
   end

   // Clamp capacity to 1 .. ENTRIES
   always_comb begin
      cap_ext = lkvc_pkg::CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = lkvc_pkg::CMP_W'(1);
      end else if (cap_ext > lkvc_pkg::CMP_W'(N)) begin
         eff_cap = lkvc_pkg::CMP_W'(N);
      end else begin
         eff_cap = cap_ext;
      end
      need_evict = (match_vec == '0) && (req_put_ff == lkvc_pkg::ACTION_PUT) &&
                   (lkvc_pkg::CMP_W'(live_count_ff) >= eff_cap);
   end

   // Hold match results for the update cycle
   always_ff @(posedge clock) begin
      if (cmd.match) begin
         hit_ff         <= (match_vec != '0);
         found_mask_ff  <= match_vec;
         found_age_ff   <= match_age;
         found_value_ff <= match_value;
         evict_ff       <= need_evict;
         victim_mask_ff <= victim_vec;
      end
   end

   // Pick the first free slot once the victim is dropped
   assign kept_vec   = valid_ff & ~(evict_ff ? victim_mask_ff : '0);
   assign free_vec   = ~kept_vec;
   assign slot_vec   = free_vec & (~free_vec + N'(1));
   assign slot_found = (slot_vec != '0);
   assign insert     = !hit_ff && (req_put_ff == lkvc_pkg::ACTION_PUT) && slot_found;

   // Next ranks, valid marks and occupancy
   always_comb begin
      valid_in      = valid_ff;
      live_count_in = live_count_ff;
      for (int i = 0; i < N; i++) begin
         age_in[i] = age_ff[i];
      end
      if (hit_ff) begin
         for (int i = 0; i < N; i++) begin
            if (found_mask_ff[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < found_age_ff)) begin
               age_in[i] = age_ff[i] + lkvc_pkg::AGE_W'(1);
            end
         end
      end else if (req_put_ff == lkvc_pkg::ACTION_PUT) begin
         valid_in      = kept_vec | slot_vec;
         live_count_in = live_count_ff - lkvc_pkg::COUNT_W'(evict_ff)
                         + lkvc_pkg::COUNT_W'(slot_found);
         if (slot_found) begin
            for (int i = 0; i < N; i++) begin
               if (slot_vec[i]) begin
                  age_in[i] = '0;
               end else if (kept_vec[i]) begin
                  age_in[i] = age_ff[i] + lkvc_pkg::AGE_W'(1);
               end
            end
         end
      end
   end

   // Control state of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         live_count_ff <= '0;
         for (int i = 0; i < N; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         valid_ff      <= valid_in;
         live_count_ff <= live_count_in;
         for (int i = 0; i < N; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   // Key and value payload
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < N; i++) begin
            if (insert && slot_vec[i]) begin
               keys_ff[i]   <= req_key_ff;
               values_ff[i] <= req_value_ff;
            end else if (hit_ff && found_mask_ff[i] &&
                         (req_put_ff == lkvc_pkg::ACTION_PUT)) begin
               values_ff[i] <= req_value_ff;
            end
         end
      end
   end

   // Output register: fill on update, drop when taken
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff        <= hit_ff;
         rsp_evicted_ff    <= evict_ff;
         rsp_read_value_ff <= (hit_ff && (req_put_ff == lkvc_pkg::ACTION_GET)) ?
                              found_value_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign status.rsp_busy = rsp_valid_ff;

endmodule

// ===== hw/rtl/lru_key_value_cache_core.sv =====
// LRU key-value cache core: 16-entry fully associative store, least recent evicted.
// The request word is captured on acceptance; the match and update states then run
// over the shared entry store and the result is registered from the update state.
// No new request is taken until then; a stalled full output holds the match state.
// Reset (synchronous): clears valid marks, ranks and occupancy; capacity reads 16.
module lru_key_value_cache_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic signed [lkvc_pkg::KEY_W-1:0]   req_lookup_key,
   input  logic signed [lkvc_pkg::VALUE_W-1:0] req_write_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic signed [lkvc_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                               rsp_evicted,
   input  logic                               csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]          csr_write_data
);

   lkvc_pkg::cmd_type    cmd;
   lkvc_pkg::status_type status;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lkvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted)
   );

`ifndef SYNTHESIS
   // An accepted word blocks further requests until it is finished
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a word is in flight");

   // The update never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !rsp_valid)
      else $error("update issued with output register full");

   // Every update presents a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid)
      else $error("update produced no result");

   // At most one command at a time
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.match, cmd.update}))
      else $error("overlapping controller commands");
`endif

endmodule

// ===== tb/sv/lru_key_value_cache_core_tb.sv =====
// Self-checking testbench for lru_key_value_cache_core: an in-bench LRU store model
// predicts every response word, which a clocked monitor checks field by field.
// Depends on lkvc_pkg and the lru_key_value_cache_core RTL only.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;

   localparam int RESET_CYCLES = 7;
   localparam int LIMIT_CYCLES = 200000;
   localparam int POOL_SIZE    = 24;
   localparam int SETTLE       = 4;

   typedef struct packed {
      logic                         action;
      logic [lkvc_pkg::KEY_W-1:0]   key;
      logic [lkvc_pkg::VALUE_W-1:0] value;
   } cache_request_type;

   typedef struct packed {
      logic                         hit;
      logic [lkvc_pkg::VALUE_W-1:0] read_value;
      logic                         evicted;
   } cache_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_action = lkvc_pkg::ACTION_GET;
   logic signed [lkvc_pkg::KEY_W-1:0]   req_lookup_key = '0;
   logic signed [lkvc_pkg::VALUE_W-1:0] req_write_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_hit;
   logic signed [lkvc_pkg::VALUE_W-1:0] rsp_read_value;
   logic                                rsp_evicted;
   logic                                csr_write_enable = 1'b0;
   logic [lkvc_pkg::CAP_W-1:0]          csr_write_data = '0;

   // Model of the store
   logic [lkvc_pkg::KEY_W-1:0]   slot_key   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VALUE_W-1:0] slot_value [lkvc_pkg::ENTRIES];
   logic                         slot_live  [lkvc_pkg::ENTRIES];
   int                           slot_rank  [lkvc_pkg::ENTRIES];
   int                           live_total;
   logic [lkvc_pkg::CAP_W-1:0]   capacity_setting = lkvc_pkg::CAP_RESET;

   cache_request_type pending_requests[$];
   cache_result_type  expected_words[$];
   logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   lru_key_value_cache_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request word to the model and return the response it should give
   function automatic cache_result_type cache_access(cache_request_type rq);
      cache_result_type res;
      int found;
      int slot;
      int victim;
      int rank;
      int limit;
      res    = '0;
      found  = -1;
      slot   = -1;
      victim = -1;
      for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
         if (found < 0 && slot_live[j] && slot_key[j] == rq.key) found = j;
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (rq.action == lkvc_pkg::ACTION_PUT) slot_value[found] = rq.value;
         else res.read_value = slot_value[found];
         // promote the entry, shifting the younger ones down by one rank
         rank = slot_rank[found];
         for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
            if (slot_live[j] && slot_rank[j] < rank) slot_rank[j]++;
         end
         slot_rank[found] = 0;
      end else if (rq.action == lkvc_pkg::ACTION_PUT) begin
         limit = int'(capacity_setting);
         if (limit < 1) limit = 1;
         if (limit > lkvc_pkg::ENTRIES) limit = lkvc_pkg::ENTRIES;
         // drop the oldest entry when the store is at its limit
         if (live_total >= limit) begin
            for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
               if (slot_live[j] && (victim < 0 || slot_rank[j] > slot_rank[victim]))
                  victim = j;
            end
            if (victim >= 0) begin
               slot_live[victim] = 1'b0;
               live_total--;
               res.evicted = 1'b1;
            end
         end
         for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
            if (slot < 0 && !slot_live[j]) slot = j;
         end
         if (slot >= 0) begin
            for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
               if (slot_live[j]) slot_rank[j]++;
            end
            slot_key[slot]   = rq.key;
            slot_value[slot] = rq.value;
            slot_live[slot]  = 1'b1;
            slot_rank[slot]  = 0;
            live_total++;
         end
      end
      return res;
   endfunction

   // Request driver: offer queued words, idling at the phase's rate
   always @(posedge clock) begin : drive_requests
      cache_request_type taken;
      cache_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.action = req_action;
            taken.key    = req_lookup_key;
            taken.value  = req_write_value;
            expected_words.insert(expected_words.size(), cache_access(taken));
         end
         // advance only once the current word has gone
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_action      <= next_req.action;
               req_lookup_key  <= next_req.key;
               req_write_value <= next_req.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted word against the oldest prediction
   always @(posedge clock) begin : check_responses
      cache_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("response word with no request outstanding");
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  error_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
                  error_count++;
               end
               if (rsp_evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_evicted);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Hold until every queued word has been taken and answered
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
   endtask

   // Write the capacity register with the block idle
   task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_setting = cap;
   endtask

   function automatic void queue_item(logic action, logic [lkvc_pkg::KEY_W-1:0] key,
                                      logic [lkvc_pkg::VALUE_W-1:0] value);
      cache_request_type rq;
      rq.action = action;
      rq.key    = key;
      rq.value  = value;
      pending_requests.insert(pending_requests.size(), rq);
   endfunction

   // One random phase: mostly keys from a small pool so hits and evictions occur
   task automatic run_phase(input logic [lkvc_pkg::CAP_W-1:0] cap, input int send_pct,
                            input int recv_pct, input int count, input int span);
      logic [lkvc_pkg::KEY_W-1:0] key;
      write_capacity(cap);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(span - 1)];
         else key = $urandom;
         queue_item(1'($urandom_range(1)), key, $urandom);
         // let the store drain once mid-phase before sending the rest
         if (i == count / 2) wait_drained();
      end
   endtask

   initial begin
      for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
         slot_key[j]   = '0;
         slot_value[j] = '0;
         slot_live[j]  = 1'b0;
         slot_rank[j]  = 0;
      end
      live_total = 0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int j = 4; j < POOL_SIZE; j++) key_pool[j] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: miss on empty store, extreme keys and values, get and put hits
      queue_item(lkvc_pkg::ACTION_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_item(lkvc_pkg::ACTION_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_item(lkvc_pkg::ACTION_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_item(lkvc_pkg::ACTION_PUT, 32'h0000_0000, 32'h0000_0000);
      queue_item(lkvc_pkg::ACTION_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(lkvc_pkg::ACTION_GET, 32'h8000_0000, 32'h1234_5678);
      queue_item(lkvc_pkg::ACTION_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_item(lkvc_pkg::ACTION_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_item(lkvc_pkg::ACTION_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_item(lkvc_pkg::ACTION_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
      queue_item(lkvc_pkg::ACTION_GET, 32'hFFFF_FFFF, 32'h0000_0000);

      // Capacity lowered below occupancy: each put miss evicts one
      write_capacity(lkvc_pkg::CAP_W'(2));
      queue_item(lkvc_pkg::ACTION_PUT, 32'h0000_0064, 32'hA5A5_A5A5);
      queue_item(lkvc_pkg::ACTION_GET, 32'h8000_0000, 32'h0000_0000);
      queue_item(lkvc_pkg::ACTION_PUT, 32'h0000_0065, 32'h5A5A_5A5A);
      queue_item(lkvc_pkg::ACTION_GET, 32'h0000_0064, 32'h0000_0000);

      // Zero capacity acts as one entry
      write_capacity(lkvc_pkg::CAP_W'(0));
      queue_item(lkvc_pkg::ACTION_PUT, 32'h0000_00C8, 32'h0000_0001);
      queue_item(lkvc_pkg::ACTION_PUT, 32'h0000_00C9, 32'h0000_0002);
      queue_item(lkvc_pkg::ACTION_GET, 32'h0000_00C8, 32'h0000_0000);
      queue_item(lkvc_pkg::ACTION_GET, 32'h0000_00C9, 32'h0000_0000);

      // Random phases across capacity settings and handshake pressure
      run_phase(lkvc_pkg::CAP_W'(16), 0, 0, 175, 20);
      run_phase(lkvc_pkg::CAP_W'(31), 81, 0, 175, POOL_SIZE);
      run_phase(lkvc_pkg::CAP_W'(1), 0, 81, 175, 4);
      run_phase(lkvc_pkg::CAP_W'(0), 14, 14, 175, 4);
      run_phase(lkvc_pkg::CAP_W'(4), 0, 0, 175, 8);
      run_phase(lkvc_pkg::CAP_W'(8), 81, 0, 175, 12);
      run_phase(lkvc_pkg::CAP_W'(16), 0, 81, 175, 20);
      run_phase(lkvc_pkg::CAP_W'($urandom_range(15, 1)), 14, 14, 175, 16);

      wait_drained();
      repeat (SETTLE * 2) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
